FILE: rtl/assert_macros.svh
// assertion helpers for the rtl, included by gbe_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: prop");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

FILE: rtl/gbe_pkg.sv
package gbe_pkg;

   localparam int MAX_GLYPH_PIXELS = 1024;
   localparam int PIXEL_INDEX_W    = $clog2(MAX_GLYPH_PIXELS);
   localparam int COLOR_W          = 16;
   localparam int CSR_INDEX_W      = 2;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_KIND  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FONT_SIZE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FG_COLOR   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BG_COLOR   = 2'd3;

   localparam logic [1:0] SIZE_12 = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_24 = 2'd2;
   localparam logic [1:0] SIZE_32 = 2'd3;

   localparam logic KIND_ASCII = 1'b0;

   typedef struct packed {
      logic [5:0] width;
      logic [5:0] height;
      logic [7:0] bytes;
   } gbe_geom_type;

   typedef struct packed {
      logic [7:0] font_byte;
      logic       glyph_done;
   } gbe_entry_type;

   function automatic gbe_geom_type gbe_geometry(input logic kind, input logic [1:0] size);
      gbe_geom_type g;
      unique case (size)
         SIZE_12: begin g.height = 6'd12; g.width = 6'd6;  g.bytes = 8'd12; end
         SIZE_16: begin g.height = 6'd16; g.width = 6'd8;  g.bytes = 8'd16; end
         SIZE_24: begin g.height = 6'd24; g.width = 6'd12; g.bytes = 8'd36; end
         SIZE_32: begin g.height = 6'd32; g.width = 6'd16; g.bytes = 8'd64; end
         default: begin g.height = 6'd16; g.width = 6'd8;  g.bytes = 8'd16; end
      endcase
      // full width glyphs are twice as wide and twice the bytes
      if (kind != KIND_ASCII) begin
         g.width = {g.width[4:0], 1'b0};
         g.bytes = {g.bytes[6:0], 1'b0};
      end
      return g;
   endfunction

endpackage

FILE: rtl/gbe_front.sv
module gbe_front
   import gbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          geom_clear,
   input  gbe_geom_type  geom,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_font_byte,
   input  logic          queue_full,
   output logic          queue_push,
   output gbe_entry_type queue_entry
);

   logic [7:0] byte_count_ff, byte_count_in;
   logic [7:0] count_next;
   logic       glyph_done;

   assign req_ready  = !queue_full;
   assign queue_push = req_valid && !queue_full;

   // count bytes of the glyph and mark the one that closes it
   always_comb begin
      count_next    = byte_count_ff + 8'd1;
      glyph_done    = (count_next >= geom.bytes);
      byte_count_in = byte_count_ff;
      if (geom_clear) begin
         byte_count_in = '0;
      end else if (queue_push) begin
         byte_count_in = glyph_done ? 8'd0 : count_next;
      end
   end

   assign queue_entry.font_byte  = req_font_byte;
   assign queue_entry.glyph_done = glyph_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

endmodule

FILE: rtl/gbe_fifo.sv
module gbe_fifo
   import gbe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  gbe_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output gbe_entry_type head
);

   gbe_entry_type                  slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]         count_ff, count_in;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/gbe_back.sv
module gbe_back
   import gbe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     geom_clear,
   input  gbe_geom_type             geom,
   input  logic [COLOR_W-1:0]       fg_color,
   input  logic [COLOR_W-1:0]       bg_color,
   input  logic                     head_valid,
   input  gbe_entry_type            head,
   output logic                     queue_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PIXEL_INDEX_W-1:0] rsp_pixel_index,
   output logic [COLOR_W-1:0]       rsp_pixel_color,
   output logic                     rsp_last_of_byte,
   output logic                     rsp_last_of_glyph
);

`include "assert_macros.svh"

   logic [5:0]               column_ff, column_in;
   logic [4:0]               row_ff, row_in;
   logic [2:0]               bit_cnt_ff, bit_cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_INDEX_W-1:0] index_ff, index_in;
   logic [COLOR_W-1:0]       color_ff, color_in;
   logic                     last_byte_ff, last_byte_in;
   logic                     last_glyph_ff, last_glyph_in;

   logic        fire;
   logic        pix_bit;
   logic [5:0]  row_next;
   logic        col_end;
   logic        last_byte;
   logic [10:0] row_offset;
   logic [11:0] index_sum;

   assign fire      = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pix_bit   = head.font_byte[3'd7 - bit_cnt_ff];
   assign row_next  = {1'b0, row_ff} + 6'd1;
   assign col_end   = (row_next >= geom.height);
   assign last_byte = col_end || (bit_cnt_ff == 3'd7);
   assign queue_pop = fire && last_byte;

   assign row_offset = row_ff * geom.width;
   assign index_sum  = {1'b0, row_offset} + {6'b0, column_ff};

   always_comb begin
      column_in     = column_ff;
      row_in        = row_ff;
      bit_cnt_in    = bit_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      index_in      = index_ff;
      color_in      = color_ff;
      last_byte_in  = last_byte_ff;
      last_glyph_in = last_glyph_ff;
      if (fire) begin
         rsp_valid_in  = 1'b1;
         index_in      = PIXEL_INDEX_W'(index_sum % 12'(MAX_GLYPH_PIXELS));
         color_in      = pix_bit ? fg_color : bg_color;
         last_byte_in  = last_byte;
         last_glyph_in = last_byte && head.glyph_done;
         bit_cnt_in    = last_byte ? 3'd0 : bit_cnt_ff + 3'd1;
         if (col_end) begin
            row_in    = '0;
            column_in = column_ff + 6'd1;
         end else begin
            row_in    = row_next[4:0];
         end
         if (last_byte && head.glyph_done) begin
            row_in    = '0;
            column_in = '0;
         end
      end
      if (geom_clear) begin
         row_in     = '0;
         column_in  = '0;
         bit_cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         bit_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         column_ff     <= column_in;
         row_ff        <= row_in;
         bit_cnt_ff    <= bit_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff      <= index_in;
      color_ff      <= color_in;
      last_byte_ff  <= last_byte_in;
      last_glyph_ff <= last_glyph_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_index   = index_ff;
   assign rsp_pixel_color   = color_ff;
   assign rsp_last_of_byte  = last_byte_ff;
   assign rsp_last_of_glyph = last_glyph_ff;

   `ASSERT_ALWAYS(a_row_in_column, clock, reset, {1'b0, row_ff} < geom.height)
   `ASSERT_ALWAYS(a_column_in_glyph, clock, reset, column_ff < geom.width)
   `ASSERT_ALWAYS(a_mid_byte_has_head, clock, reset, (bit_cnt_ff == 3'd0) || head_valid)
   `ASSERT_NEXT(a_glyph_end_clears, clock, reset, fire && last_byte && head.glyph_done,
                (row_ff == 5'd0) && (column_ff == 6'd0) && rsp_last_of_glyph)

endmodule

FILE: rtl/glyph_bitmap_expander.sv
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_font_byte
// rsp       out        rsp_valid/rsp_ready    rsp_pixel_index, rsp_pixel_color,
//                                             rsp_last_of_byte, rsp_last_of_glyph
// csr       in         csr_write_en           csr_index, csr_write_data
//
// one pixel per cycle, when ready and a byte is queued, out of a single output
// register: 8 pixels per byte, 4 for the byte that closes a 12-row column
// reset is synchronous and active high; clears counters, queue and config
// a two-entry queue parts byte intake from pixel expansion, so bytes keep
// arriving while pixels stall until the queue is full; the next queued byte
// starts as soon as the last pixel of the previous one is taken, with no bubble
module glyph_bitmap_expander
   import gbe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_font_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [PIXEL_INDEX_W-1:0] rsp_pixel_index,
   output logic [COLOR_W-1:0]       rsp_pixel_color,
   output logic                     rsp_last_of_byte,
   output logic                     rsp_last_of_glyph,
   input  logic                     csr_write_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [COLOR_W-1:0]       csr_write_data
);

   // configuration registers
   logic               font_kind_ff, font_kind_in;
   logic [1:0]         font_size_ff, font_size_in;
   logic [COLOR_W-1:0] fg_color_ff, fg_color_in;
   logic [COLOR_W-1:0] bg_color_ff, bg_color_in;

   logic          geom_clear;
   gbe_geom_type  geom;
   logic          queue_full;
   logic          queue_push;
   logic          queue_pop;
   logic          queue_not_empty;
   gbe_entry_type queue_entry;
   gbe_entry_type queue_head;

   // register decode; a geometry write abandons the glyph in progress
   always_comb begin
      font_kind_in = font_kind_ff;
      font_size_in = font_size_ff;
      fg_color_in  = fg_color_ff;
      bg_color_in  = bg_color_ff;
      geom_clear   = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FONT_KIND: begin
               font_kind_in = csr_write_data[0];
               geom_clear   = 1'b1;
            end
            CSR_FONT_SIZE: begin
               font_size_in = csr_write_data[1:0];
               geom_clear   = 1'b1;
            end
            CSR_FG_COLOR: fg_color_in = csr_write_data;
            CSR_BG_COLOR: bg_color_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         font_kind_ff <= KIND_ASCII;
         font_size_ff <= SIZE_16;
         fg_color_ff  <= '1;
         bg_color_ff  <= '0;
      end else begin
         font_kind_ff <= font_kind_in;
         font_size_ff <= font_size_in;
         fg_color_ff  <= fg_color_in;
         bg_color_ff  <= bg_color_in;
      end
   end

   // glyph width, height and byte count from the current font
   assign geom = gbe_geometry(font_kind_ff, font_size_ff);

   // front: takes bytes, tracks the glyph byte count
   gbe_front u_front (
      .clock         (clock),
      .reset         (reset),
      .geom_clear    (geom_clear),
      .geom          (geom),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_font_byte (req_font_byte),
      .queue_full    (queue_full),
      .queue_push    (queue_push),
      .queue_entry   (queue_entry)
   );

   // short queue of classified bytes
   gbe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .pop        (queue_pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (queue_head)
   );

   // back: walks the column, one pixel per transfer
   gbe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .geom_clear        (geom_clear),
      .geom              (geom),
      .fg_color          (fg_color_ff),
      .bg_color          (bg_color_ff),
      .head_valid        (queue_not_empty),
      .head              (queue_head),
      .queue_pop         (queue_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_last_of_glyph (rsp_last_of_glyph)
   );

endmodule

FILE: tb/sv/glyph_pixel_checker.sv
module glyph_pixel_checker
   import gbe_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [7:0]               req_font_byte,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [PIXEL_INDEX_W-1:0] rsp_pixel_index,
   input  logic [COLOR_W-1:0]       rsp_pixel_color,
   input  logic                     rsp_last_of_byte,
   input  logic                     rsp_last_of_glyph,
   input  logic                     csr_write_en,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [COLOR_W-1:0]       csr_write_data,
   output int                       mismatch_count,
   output int                       pixels_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [PIXEL_INDEX_W-1:0] pos;
      logic [COLOR_W-1:0]       color;
      logic                     byte_end;
      logic                     glyph_end;
   } glyph_pixel_type;

   glyph_pixel_type    expected_pixels[$];

   logic               font_kind;
   logic [1:0]         font_size;
   logic [COLOR_W-1:0] fg_color;
   logic [COLOR_W-1:0] bg_color;
   logic [5:0]         column;
   logic [4:0]         row;
   logic [7:0]         byte_count;

   task automatic restart_glyph();
      column     = '0;
      row        = '0;
      byte_count = '0;
   endtask

   // one font byte runs down the current column, msb first
   task automatic expand_byte(input logic [7:0] font_bits);
      int              width;
      int              height;
      int              glyph_len;
      int              next_row;
      logic [7:0]      bits;
      logic            glyph_done;
      logic            column_end;
      glyph_pixel_type px;
      case (font_size)
         SIZE_12: begin width = 6;  height = 12; glyph_len = 12; end
         SIZE_16: begin width = 8;  height = 16; glyph_len = 16; end
         SIZE_24: begin width = 12; height = 24; glyph_len = 36; end
         default: begin width = 16; height = 32; glyph_len = 64; end
      endcase
      if (font_kind != KIND_ASCII) begin
         width     = 2 * width;
         glyph_len = 2 * glyph_len;
      end
      bits       = font_bits;
      byte_count = byte_count + 8'd1;
      glyph_done = (byte_count >= glyph_len);
      for (int j = 0; j < 8; j++) begin
         px.pos   = PIXEL_INDEX_W'((column + row * width) % MAX_GLYPH_PIXELS);
         px.color = bits[7] ? fg_color : bg_color;
         bits     = bits << 1;
         next_row = row + 1;
         column_end = (next_row >= height);
         if (column_end) begin
            row    = '0;
            column = column + 6'd1;
         end else begin
            row = next_row[4:0];
         end
         // rest of the byte is dropped once the column is full
         px.byte_end  = column_end || (j == 7);
         px.glyph_end = px.byte_end && glyph_done;
         expected_pixels.push_back(px);
         if (column_end) break;
      end
      if (glyph_done) restart_glyph();
   endtask

   task automatic check_pixel();
      glyph_pixel_type want;
      glyph_pixel_type got;
      got = '{rsp_pixel_index, rsp_pixel_color, rsp_last_of_byte, rsp_last_of_glyph};
      if (expected_pixels.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: pixel with none expected: pos %0d color %h byte_end %b glyph_end %b",
                     $time, got.pos, got.color, got.byte_end, got.glyph_end);
         end
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pos !== want.pos || got.color !== want.color ||
          got.byte_end !== want.byte_end || got.glyph_end !== want.glyph_end) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: pixel mismatch: expected pos %0d color %h byte_end %b glyph_end %b",
                     $time, want.pos, want.color, want.byte_end, want.glyph_end);
            $display("%0t:                 got      pos %0d color %h byte_end %b glyph_end %b",
                     $time, got.pos, got.color, got.byte_end, got.glyph_end);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         font_kind = KIND_ASCII;
         font_size = SIZE_16;
         fg_color  = 16'hFFFF;
         bg_color  = 16'h0000;
         restart_glyph();
         expected_pixels.delete();
         pixels_pending = 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_FONT_KIND: begin
                  font_kind = csr_write_data[0];
                  restart_glyph();
               end
               CSR_FONT_SIZE: begin
                  font_size = csr_write_data[1:0];
                  restart_glyph();
               end
               CSR_FG_COLOR: fg_color = csr_write_data;
               CSR_BG_COLOR: bg_color = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) expand_byte(req_font_byte);
         if (rsp_valid && rsp_ready) check_pixel();
         pixels_pending = expected_pixels.size();
      end
   end

endmodule

FILE: tb/sv/glyph_bitmap_expander_tb.sv
module glyph_bitmap_expander_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gbe_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 5;
   localparam int RANDOM_ITEMS   = 440;
   localparam int IDLE_PAUSE     = 4;
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 2000;

   // receiver behavior, switched to a random mode when its countdown runs out
   typedef enum int {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_SPARSE,
      READY_PATTERN
   } ready_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [7:0]               req_font_byte = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [PIXEL_INDEX_W-1:0] rsp_pixel_index;
   logic [COLOR_W-1:0]       rsp_pixel_color;
   logic                     rsp_last_of_byte;
   logic                     rsp_last_of_glyph;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [COLOR_W-1:0]       csr_write_data = '0;

   int                       mismatch_count;
   int                       pixels_pending;

   // sender burst bookkeeping
   int                       burst_left = 1;

   // receiver stall state
   ready_mode_type           ready_mode = READY_ALWAYS;
   int                       ready_left = 0;
   int                       ready_tick = 0;

   int                       quiet_cycles = 0;

   always #(CLOCK_HALF) clock = ~clock;

   glyph_bitmap_expander dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_font_byte     (req_font_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_last_of_glyph (rsp_last_of_glyph),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   // watches both channels and the register port, predicts every pixel
   glyph_pixel_checker pixel_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_font_byte     (req_font_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_of_byte  (rsp_last_of_byte),
      .rsp_last_of_glyph (rsp_last_of_glyph),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .mismatch_count    (mismatch_count),
      .pixels_pending    (pixels_pending)
   );

   // receiver: stall pattern of its own, independent of the sender
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         ready_left = $urandom_range(16, 96);
      end else begin
         ready_left--;
      end
      ready_tick++;
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_MOSTLY: rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= ((ready_tick % 7) != 3) && ((ready_tick % 7) != 6);
      endcase
   end

   // watchdog: any transfer or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // bytes per glyph, used to shape well-formed glyph sequences
   function automatic int glyph_length(input logic kind, input logic [1:0] size);
      int len;
      case (size)
         SIZE_12: len = 12;
         SIZE_16: len = 16;
         SIZE_24: len = 36;
         default: len = 64;
      endcase
      return (kind == KIND_ASCII) ? len : 2 * len;
   endfunction

   // all-clear and all-set bytes get extra weight
   function automatic logic [7:0] random_font_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after the transfer;
   // valid stays high so the next call can go back to back
   task automatic send_byte(input logic [7:0] font_bits);
      req_valid     <= 1'b1;
      req_font_byte <= font_bits;
      do begin
         @(posedge clock);
      end while (!req_ready);
      @(negedge clock);
   endtask

   // drop valid and scramble the payload while idle
   task automatic pause_sender(input int cycles);
      req_valid     <= 1'b0;
      req_font_byte <= 8'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   // bursts: mostly short, sometimes long stretches with no gap at all
   task automatic send_paced(input logic [7:0] font_bits);
      send_byte(font_bits);
      burst_left--;
      if (burst_left <= 0) begin
         pause_sender($urandom_range(1, 10));
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
   endtask

   // registers only change once every predicted pixel has come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pixels_pending != 0) @(negedge clock);
      repeat (IDLE_PAUSE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [COLOR_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_INDEX_W'($urandom);
      csr_write_data <= COLOR_W'($urandom);
      @(negedge clock);
   endtask

   initial begin
      logic [7:0]         directed_bytes[$];
      logic               phase_kind;
      logic [1:0]         phase_size;
      logic [COLOR_W-1:0] fg;
      logic [COLOR_W-1:0] bg;
      logic               keep_geometry;
      int                 glyph_len;
      int                 glyph_count;
      int                 partial_len;
      int                 random_sent;
      int                 phase;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // a couple of bytes on the reset settings: 8x16 ascii, white on black
      directed_bytes = '{8'hA5, 8'h5A};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_idle();

      // 6x12 ascii: two bytes per column, the second fills only four rows
      // and its low nibble is dropped; twelve bytes close the glyph
      write_reg(CSR_FONT_KIND, {15'h7FFF, KIND_ASCII});
      write_reg(CSR_FONT_SIZE, {14'h3FFF, SIZE_12});
      write_reg(CSR_FG_COLOR, 16'hFFFF);
      write_reg(CSR_BG_COLOR, 16'h0000);
      directed_bytes = '{8'hFF, 8'h00, 8'h80, 8'h0F, 8'h01, 8'hF0,
                         8'hAA, 8'h55, 8'h7F, 8'hFE, 8'hC3, 8'h3C};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      // start of a new glyph, then abandoned by a geometry change
      directed_bytes = '{8'hFF, 8'h00, 8'hA5};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_idle();
      write_reg(CSR_FONT_KIND, 16'h0001);
      write_reg(CSR_FG_COLOR, 16'h0000);
      write_reg(CSR_BG_COLOR, 16'hFFFF);
      write_reg(CSR_FONT_SIZE, {14'h0000, SIZE_32});

      // 32x32 hanzi: four full bytes fill one column, then the column advances
      directed_bytes = '{8'hFF, 8'h00, 8'h81, 8'h7E};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

      // random part: the first eight phases sweep every geometry, later ones
      // favor the small glyphs; some phases leave a glyph half done, and some
      // only touch the colors so a glyph carries on across the write
      random_sent = 0;
      for (phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
         wait_idle();
         keep_geometry = (phase >= 8) && ($urandom_range(0, 4) == 0);
         if (!keep_geometry) begin
            if (phase < 8) begin
               phase_kind = phase[0];
               phase_size = phase[2:1];
            end else begin
               phase_kind = 1'($urandom_range(0, 1));
               phase_size = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(2, 3))
                                                        : 2'($urandom_range(0, 1));
            end
            write_reg(CSR_FONT_KIND, {15'($urandom), phase_kind});
            write_reg(CSR_FONT_SIZE, {14'($urandom), phase_size});
         end

         // color extremes first, then random, now and then equal colors
         case (phase)
            0: begin fg = 16'hFFFF; bg = 16'h0000; end
            1: begin fg = 16'h0000; bg = 16'hFFFF; end
            default: begin
               fg = COLOR_W'($urandom);
               bg = COLOR_W'($urandom);
               if ($urandom_range(0, 7) == 0) bg = fg;
            end
         endcase
         write_reg(CSR_FG_COLOR, fg);
         write_reg(CSR_BG_COLOR, bg);

         glyph_len = glyph_length(phase_kind, phase_size);
         if (keep_geometry) begin
            glyph_count = 0;
            partial_len = $urandom_range(1, glyph_len);
         end else begin
            glyph_count = (phase < 8 || glyph_len > 36) ? 1 : $urandom_range(1, 3);
            partial_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, glyph_len - 1) : 0;
         end
         repeat (glyph_count * glyph_len + partial_len) begin
            send_paced(random_font_byte());
            random_sent++;
         end
      end

      // drain, then give a stray pixel time to show up
      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && pixels_pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/gbe_pkg.sv
rtl/gbe_front.sv
rtl/gbe_fifo.sv
rtl/gbe_back.sv
rtl/glyph_bitmap_expander.sv
tb/sv/glyph_pixel_checker.sv
tb/sv/glyph_bitmap_expander_tb.sv
